>>> hw/rtl/sorted_four_entry_key_table_unit_macros.svh
// Assertion helpers used by the back end of the key table.
`ifndef SORTED_FOUR_ENTRY_KEY_TABLE_UNIT_MACROS_SVH
`define SORTED_FOUR_ENTRY_KEY_TABLE_UNIT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SFKT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define SFKT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/sfkt_pkg.sv
`default_nettype none

package sfkt_pkg;

    // Table geometry.
    localparam int CAPACITY    = 4;
    localparam int VALUE_WIDTH = 64;
    localparam int SLOT_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    // Fixed field widths of the channels.
    localparam int REQ_W    = 3;
    localparam int KEY_W    = 8;
    localparam int CHILD_W  = 64;
    localparam int POS_W    = 2;
    localparam int COUNT_W  = 3;

    // Depth of the queue between the front and the back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W        = $clog2(QUEUE_DEPTH);
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    // Request codes as they arrive on the request channel.
    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 3'd0,
        REQ_REMOVE = 3'd1,
        REQ_CHANGE = 3'd2,
        REQ_LOOKUP = 3'd3,
        REQ_SEEK   = 3'd4,
        REQ_RANGE  = 3'd5
    } t_req_code;

    // Operations after classification; OP_NONE always answers not-found.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_REMOVE,
        OP_CHANGE,
        OP_LOOKUP,
        OP_SEEK,
        OP_RANGE
    } t_op;

    // Back-end sequencer states.
    typedef enum logic {
        BK_IDLE,
        BK_RANGE
    } t_back_state;

    // A classified request.
    typedef struct packed {
        t_op                    op;
        logic [KEY_W-1:0]       key;
        logic [KEY_W-1:0]       key_upper;
        logic [VALUE_WIDTH-1:0] value;
    } t_cmd;

    // A request together with its valid flag.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_beat;

    // One result item.
    typedef struct packed {
        logic               found;
        logic [KEY_W-1:0]   key_out;
        logic [CHILD_W-1:0] child_out;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] entry_count;
        logic               table_full;
        logic               last;
    } t_rsp;

    // Outcome of a first-set-bit search over the slots.
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } t_pick;

    // Finds the lowest set bit of a slot vector.
    function automatic t_pick first_set(input logic [CAPACITY-1:0] vec);
        t_pick pick;
        pick = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (vec[i]) begin
                pick.hit  = 1'b1;
                pick.slot = SLOT_W'(i);
            end
        end
        return pick;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sfkt_if.sv
`default_nettype none

// Request channel: one table operation per request.
interface sfkt_req_if;
    import sfkt_pkg::*;

    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [KEY_W-1:0]   key;
    logic [KEY_W-1:0]   key_upper;
    logic [CHILD_W-1:0] child_value;

    modport source (output valid, output req_type, output key, output key_upper,
                    output child_value, input ready);
    modport sink   (input valid, input req_type, input key, input key_upper,
                    input child_value, output ready);
endinterface

// Result channel: one or more results per request.
interface sfkt_rsp_if;
    import sfkt_pkg::*;

    logic               valid;
    logic               ready;
    logic               found;
    logic [KEY_W-1:0]   key_out;
    logic [CHILD_W-1:0] child_out;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] entry_count;
    logic               table_full;
    logic               last;

    modport source (output valid, output found, output key_out, output child_out,
                    output position, output entry_count, output table_full,
                    output last, input ready);
    modport sink   (input valid, input found, input key_out, input child_out,
                    input position, input entry_count, input table_full,
                    input last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sorted_four_entry_key_table_unit.sv
// Sorted key table of up to four entries, each an 8-bit key with a 64-bit child value, kept
// in key order. Requests (insert, remove, change, lookup, seek, range) enter on i_req and
// results leave on o_rsp; every result carries the entry count and the full flag after the
// operation, and the final result of a request has last set. A request passes a holding
// stage in the front end and a two-entry queue, then the back end executes it into the result
// register. The back end executes one request per cycle while the result register can take
// a new result; a range request holds it while it reports its matching entries, up to four,
// one per result. An insert into a full table and a remove, change or lookup of an absent
// key give a single not-found result and leave the table unchanged.
`default_nettype none

module sorted_four_entry_key_table_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfkt_req_if.sink    i_req,
    sfkt_rsp_if.source  o_rsp
);
    import sfkt_pkg::*;

    t_cmd_beat push;
    t_cmd_beat head;
    logic      push_ready;
    logic      pop;

    // Accept and classify requests.
    sfkt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_push_ready (push_ready),
        .o_push       (push)
    );

    // Decouple the front end from the back end.
    sfkt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .o_head       (head),
        .i_pop        (pop)
    );

    // Execute requests on the table and produce results.
    sfkt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

>>> hw/rtl/sfkt_front.sv
`default_nettype none

module sfkt_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sfkt_req_if.sink            i_req,
    input  logic                i_push_ready,
    output sfkt_pkg::t_cmd_beat o_push
);
    import sfkt_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;

    // The stage takes a new request when it is empty or drains this cycle.
    assign i_req.ready = !r_valid || i_push_ready;
    assign accept      = i_req.valid && i_req.ready;

    // Classify the request; a range with crossed bounds can never match.
    always_comb begin
        n_cmd.key       = i_req.key;
        n_cmd.key_upper = i_req.key_upper;
        n_cmd.value     = VALUE_WIDTH'(i_req.child_value);
        unique case (i_req.req_type)
            REQ_INSERT: n_cmd.op = OP_INSERT;
            REQ_REMOVE: n_cmd.op = OP_REMOVE;
            REQ_CHANGE: n_cmd.op = OP_CHANGE;
            REQ_LOOKUP: n_cmd.op = OP_LOOKUP;
            REQ_SEEK:   n_cmd.op = OP_SEEK;
            REQ_RANGE:  n_cmd.op = (i_req.key > i_req.key_upper) ? OP_NONE : OP_RANGE;
            default:    n_cmd.op = OP_NONE;
        endcase
    end

    // Valid flag of the holding stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload of the holding stage.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_push.valid = r_valid;
    assign o_push.cmd   = r_cmd;

endmodule

`default_nettype wire

>>> hw/rtl/sfkt_queue.sv
`default_nettype none

module sfkt_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sfkt_pkg::t_cmd_beat i_push,
    output logic                o_push_ready,
    output sfkt_pkg::t_cmd_beat o_head,
    input  logic                i_pop
);
    import sfkt_pkg::*;

    t_cmd            r_slots [QUEUE_DEPTH];
    logic [QP_W-1:0] r_wr;
    logic [QP_W-1:0] r_rd;
    logic [QC_W-1:0] r_cnt;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_cnt != QC_W'(QUEUE_DEPTH));
    assign push         = i_push.valid && o_push_ready;
    assign pop          = i_pop && (r_cnt != '0);

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slots[r_wr] <= i_push.cmd;
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_slots[r_rd];

endmodule

`default_nettype wire

>>> hw/rtl/sfkt_back.sv
`default_nettype none
`include "sorted_four_entry_key_table_unit_macros.svh"

module sfkt_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sfkt_pkg::t_cmd_beat i_head,
    output logic                o_pop,
    sfkt_rsp_if.source          o_rsp
);
    import sfkt_pkg::*;

    // Table contents, kept sorted by key in the slots below the count.
    logic [KEY_W-1:0]       r_keys [CAPACITY];
    logic [VALUE_WIDTH-1:0] r_vals [CAPACITY];
    logic [KEY_W-1:0]       n_keys [CAPACITY];
    logic [VALUE_WIDTH-1:0] n_vals [CAPACITY];
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;

    // Range sequencing: slots still to be reported.
    t_back_state         r_state;
    t_back_state         n_state;
    logic [CAPACITY-1:0] r_mask;
    logic [CAPACITY-1:0] n_mask;

    // Output register.
    logic r_out_valid;
    logic n_out_valid;
    t_rsp r_out;
    t_rsp n_out;

    logic                   can_out;
    logic                   full;
    t_cmd                   cmd;
    logic [CAPACITY-1:0]    occ;
    logic [CAPACITY-1:0]    lt_vec;
    logic [CAPACITY-1:0]    eq_vec;
    logic [CAPACITY-1:0]    ge_vec;
    logic [CAPACITY-1:0]    rng_vec;
    logic [CAPACITY-1:0]    sel_vec;
    logic [CAPACITY-1:0]    rest;
    t_pick                  ins;
    t_pick                  sel;
    logic [KEY_W-1:0]       rd_key;
    logic [VALUE_WIDTH-1:0] rd_val;

    assign cmd     = i_head.cmd;
    assign can_out = !r_out_valid || o_rsp.ready;
    assign full    = (r_count == CNT_W'(CAPACITY));

    // Compare the request key against every slot in parallel.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            occ[i]     = (CNT_W'(i) < r_count);
            lt_vec[i]  = occ[i] && (r_keys[i] < cmd.key);
            eq_vec[i]  = occ[i] && (r_keys[i] == cmd.key);
            ge_vec[i]  = occ[i] && (r_keys[i] >= cmd.key);
            rng_vec[i] = ge_vec[i] && (r_keys[i] <= cmd.key_upper);
        end
    end

    // Choose the slot vector to search, then the single read of the table.
    always_comb begin
        if (r_state == BK_RANGE) begin
            sel_vec = r_mask;
        end else begin
            unique case (cmd.op)
                OP_REMOVE, OP_CHANGE, OP_LOOKUP: sel_vec = eq_vec;
                OP_SEEK:                         sel_vec = ge_vec;
                OP_RANGE:                        sel_vec = rng_vec;
                default:                         sel_vec = '0;
            endcase
        end
    end

    assign ins    = first_set(~lt_vec);
    assign sel    = first_set(sel_vec);
    assign rd_key = r_keys[sel.slot];
    assign rd_val = r_vals[sel.slot];

    // Matches left behind the one reported now.
    always_comb begin
        rest = sel_vec;
        rest[sel.slot] = 1'b0;
    end

    // Sequencer: next state, table update and result.
    always_comb begin
        n_state     = r_state;
        n_mask      = r_mask;
        n_count     = r_count;
        n_keys      = r_keys;
        n_vals      = r_vals;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out       = r_out;
        o_pop       = 1'b0;

        // The default answer reports the first selected slot, or not-found if none, with the count after the operation.
        if (can_out) begin
            n_out             = '0;
            n_out.last        = 1'b1;
            n_out.found       = sel.hit;
            n_out.key_out     = sel.hit ? rd_key : '0;
            n_out.child_out   = sel.hit ? CHILD_W'(rd_val) : '0;
            n_out.position    = sel.hit ? POS_W'(sel.slot) : '0;
        end

        unique case (r_state)
            BK_IDLE: begin
                if (i_head.valid && can_out) begin
                    o_pop       = 1'b1;
                    n_out_valid = 1'b1;
                    case (cmd.op)
                        OP_INSERT: begin
                            if (full) begin
                                n_out = '0;
                                n_out.last = 1'b1;
                            end else begin
                                // Shift the entries at and behind the slot up by one.
                                for (int i = 1; i < CAPACITY; i++) begin
                                    if (SLOT_W'(i) > ins.slot) begin
                                        n_keys[i] = r_keys[i-1];
                                        n_vals[i] = r_vals[i-1];
                                    end
                                end
                                n_keys[ins.slot] = cmd.key;
                                n_vals[ins.slot] = cmd.value;
                                n_count          = r_count + 1'b1;
                                n_out.found      = 1'b1;
                                n_out.key_out    = cmd.key;
                                n_out.child_out  = CHILD_W'(cmd.value);
                                n_out.position   = POS_W'(ins.slot);
                            end
                        end
                        OP_REMOVE: begin
                            if (sel.hit) begin
                                // Close the gap behind the removed slot.
                                for (int i = 0; i < CAPACITY - 1; i++) begin
                                    if (SLOT_W'(i) >= sel.slot) begin
                                        n_keys[i] = r_keys[i+1];
                                        n_vals[i] = r_vals[i+1];
                                    end
                                end
                                n_count = r_count - 1'b1;
                            end
                        end
                        OP_CHANGE: begin
                            if (sel.hit) begin
                                n_vals[sel.slot] = cmd.value;
                                n_out.child_out  = CHILD_W'(cmd.value);
                            end
                        end
                        OP_RANGE: begin
                            // Report the first match now and the rest one per cycle while the output can take them.
                            if (rest != '0) begin
                                n_out.last = 1'b0;
                                n_mask     = rest;
                                n_state    = BK_RANGE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            BK_RANGE: begin
                if (can_out) begin
                    n_out_valid = 1'b1;
                    n_mask      = rest;
                    n_out.last  = (rest == '0);
                    if (rest == '0) begin
                        n_state = BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase

        n_out.entry_count = COUNT_W'(n_count);
        n_out.table_full  = (n_count == CNT_W'(CAPACITY));
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Table contents, range mask and result payload.
    always_ff @(posedge i_clk) begin
        r_keys <= n_keys;
        r_vals <= n_vals;
        r_mask <= n_mask;
        r_out  <= n_out;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found       = r_out.found;
    assign o_rsp.key_out     = r_out.key_out;
    assign o_rsp.child_out   = r_out.child_out;
    assign o_rsp.position    = r_out.position;
    assign o_rsp.entry_count = r_out.entry_count;
    assign o_rsp.table_full  = r_out.table_full;
    assign o_rsp.last        = r_out.last;

    `SFKT_ASSERT(a_count_cap, i_clk, i_rst_n, r_count <= CNT_W'(CAPACITY), "entry count above capacity")
    `SFKT_ASSERT(a_range_mask, i_clk, i_rst_n, (r_state != BK_RANGE) || (r_mask != '0), "range walk with no match left")
    `SFKT_ASSERT_NEXT(a_pop_result, i_clk, i_rst_n, o_pop, r_out_valid, "executed request left no result")
    `SFKT_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, o_pop && (cmd.op == OP_INSERT) && !full, r_count == $past(r_count) + 1'b1, "insert did not add an entry")

endmodule

`default_nettype wire
